/* hw/rtl/bpcl_pkg.sv */
// Shared widths, register index codes and the percent curve for the
// battery presence and charger latch block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpcl_pkg;

   localparam int MV_W      = 14;   // millivolt fields
   localparam int DROP_W    = 10;   // release drop and removal jump
   localparam int PCT_W     = 7;    // percent 0..100
   localparam int CSR_IDX_W = 3;
   localparam int PCT_PTS   = 8;    // points on the percent curve
   localparam int SEG_W     = 3;    // segment number 0..7
   localparam int SPAN_W    = 8;    // widest segment span is 220 mV
   localparam int COEF_W    = 14;
   localparam int COEF_SHIFT = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PLAUSIBLE    = 3'd0,
      CSR_MAX_PLAUSIBLE    = 3'd1,
      CSR_TERMINATION      = 3'd2,
      CSR_RELEASE_DROP     = 3'd3,
      CSR_FLOAT            = 3'd4,
      CSR_FLOAT_TRANSITION = 3'd5,
      CSR_REMOVAL_JUMP     = 3'd6,
      CSR_REINSERT         = 3'd7
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [MV_W-1:0]   MIN_PLAUSIBLE_RST    = 14'd2800;
   localparam logic [MV_W-1:0]   MAX_PLAUSIBLE_RST    = 14'd4500;
   localparam logic [MV_W-1:0]   TERMINATION_RST      = 14'd4100;
   localparam logic [DROP_W-1:0] RELEASE_DROP_RST     = 10'd50;
   localparam logic [MV_W-1:0]   FLOAT_RST            = 14'd4150;
   localparam logic [MV_W-1:0]   FLOAT_TRANSITION_RST = 14'd4180;
   localparam logic [DROP_W-1:0] REMOVAL_JUMP_RST     = 10'd35;
   localparam logic [MV_W-1:0]   REINSERT_RST         = 14'd4120;

   // Percent curve, mV breakpoints and percent at each point
   localparam logic [MV_W-1:0] PCT_MV [PCT_PTS] = '{
      14'd3300, 14'd3520, 14'd3640, 14'd3760,
      14'd3880, 14'd4000, 14'd4120, 14'd4200
   };
   localparam logic [PCT_W-1:0] PCT_VAL [PCT_PTS] = '{
      7'd0, 7'd10, 7'd25, 7'd45, 7'd65, 7'd82, 7'd96, 7'd100
   };
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Slope of segment i (ending at point i), ceil(2^16 * dp / span).
   // Exact floor for any offset within the span since offset * error < 2^16.
   localparam logic [COEF_W-1:0] PCT_COEF [PCT_PTS] = '{
      14'd0,
      COEF_W'((10 * 65536 + 219) / 220),
      COEF_W'((15 * 65536 + 119) / 120),
      COEF_W'((20 * 65536 + 119) / 120),
      COEF_W'((20 * 65536 + 119) / 120),
      COEF_W'((17 * 65536 + 119) / 120),
      COEF_W'((14 * 65536 + 119) / 120),
      COEF_W'((4 * 65536 + 79) / 80)
   };

endpackage

`default_nettype wire

/* hw/rtl/bpcl_percent.sv */
// Piecewise-linear battery percent from millivolts, fraction truncated.
// Depends on bpcl_pkg for the curve and segment slopes.
`timescale 1ns / 1ps
`default_nettype none

module bpcl_percent (
   input  wire logic [bpcl_pkg::MV_W-1:0]  voltage_mv,
   output logic      [bpcl_pkg::PCT_W-1:0] percent
);

   logic [bpcl_pkg::SEG_W-1:0]                        seg;
   logic                                              found;
   logic                                              at_floor;
   logic [bpcl_pkg::MV_W-1:0]                         seg_lo;
   logic [bpcl_pkg::MV_W-1:0]                         offset_full;
   logic [bpcl_pkg::SPAN_W-1:0]                       offset;
   logic [bpcl_pkg::SPAN_W+bpcl_pkg::COEF_W-1:0]      product;
   logic [bpcl_pkg::SPAN_W+bpcl_pkg::COEF_W-bpcl_pkg::COEF_SHIFT-1:0] step;

   // first breakpoint at or above the voltage; lowest index wins
   always_comb begin
      seg   = '0;
      found = 1'b0;
      for (int i = bpcl_pkg::PCT_PTS - 1; i >= 1; i--) begin
         if (voltage_mv <= bpcl_pkg::PCT_MV[i]) begin
            seg   = bpcl_pkg::SEG_W'(i);
            found = 1'b1;
         end
      end
   end

   assign at_floor    = voltage_mv <= bpcl_pkg::PCT_MV[0];
   assign seg_lo      = bpcl_pkg::PCT_MV[seg - bpcl_pkg::SEG_W'(1)];
   assign offset_full = voltage_mv - seg_lo;
   assign offset      = offset_full[bpcl_pkg::SPAN_W-1:0];
   assign product     = (bpcl_pkg::SPAN_W + bpcl_pkg::COEF_W)'(offset)
                      * (bpcl_pkg::SPAN_W + bpcl_pkg::COEF_W)'(bpcl_pkg::PCT_COEF[seg]);
   assign step        = product[bpcl_pkg::SPAN_W+bpcl_pkg::COEF_W-1:bpcl_pkg::COEF_SHIFT];

   always_comb begin
      if (at_floor) begin
         percent = '0;
      end else if (found) begin
         percent = bpcl_pkg::PCT_VAL[seg - bpcl_pkg::SEG_W'(1)]
                 + bpcl_pkg::PCT_W'(step);
      end else begin
         percent = bpcl_pkg::PCT_FULL;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/battery_presence_and_charger_latch.sv */
// Top level: battery presence and charger power latch with percent readout.
// Depends on bpcl_pkg and bpcl_percent.
//
//   Channel  | Ports                                      | Direction
//   ---------+--------------------------------------------+----------
//   req      | req_valid/req_stall, voltage, pin, host    | in
//   rsp      | rsp_valid/rsp_stall, cell/power flags, pct | out
//   csr      | csr_valid/csr_ready, csr_index, csr_wdata  | in (write)
//
// One sample per cycle sustained while rsp is not stalled. A sample is
// captured in the input register at the req transfer; once the result
// register is free, the latch update and percent lookup land in it and rsp_valid rises.
// Synchronous active-high reset clears latches, history and both valids and
// loads the register defaults. csr_ready is always high.
// req_stall rises only when both the input and result registers are full
// and rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module battery_presence_and_charger_latch (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // sample input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bpcl_pkg::MV_W-1:0]     req_voltage_mv,
   input  wire logic                          req_charge_pin,
   input  wire logic                          req_usb_host,
   // result output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_cell_fitted,
   output logic                               rsp_ext_power,
   output logic                               rsp_charging,
   output logic [bpcl_pkg::PCT_W-1:0]         rsp_percent,
   // register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bpcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bpcl_pkg::MV_W-1:0]     csr_wdata
);

   localparam int MV_W   = bpcl_pkg::MV_W;
   localparam int DROP_W = bpcl_pkg::DROP_W;
   localparam int PCT_W  = bpcl_pkg::PCT_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [MV_W-1:0]   min_plausible_ff, max_plausible_ff, termination_ff;
   logic [MV_W-1:0]   float_ff, float_transition_ff, reinsert_ff;
   logic [DROP_W-1:0] release_drop_ff, removal_jump_ff;
   bpcl_pkg::csr_index_type csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = bpcl_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_plausible_ff    <= bpcl_pkg::MIN_PLAUSIBLE_RST;
         max_plausible_ff    <= bpcl_pkg::MAX_PLAUSIBLE_RST;
         termination_ff      <= bpcl_pkg::TERMINATION_RST;
         release_drop_ff     <= bpcl_pkg::RELEASE_DROP_RST;
         float_ff            <= bpcl_pkg::FLOAT_RST;
         float_transition_ff <= bpcl_pkg::FLOAT_TRANSITION_RST;
         removal_jump_ff     <= bpcl_pkg::REMOVAL_JUMP_RST;
         reinsert_ff         <= bpcl_pkg::REINSERT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_sel)
            bpcl_pkg::CSR_MIN_PLAUSIBLE:    min_plausible_ff    <= csr_wdata;
            bpcl_pkg::CSR_MAX_PLAUSIBLE:    max_plausible_ff    <= csr_wdata;
            bpcl_pkg::CSR_TERMINATION:      termination_ff      <= csr_wdata;
            bpcl_pkg::CSR_RELEASE_DROP:     release_drop_ff     <= csr_wdata[DROP_W-1:0];
            bpcl_pkg::CSR_FLOAT:            float_ff            <= csr_wdata;
            bpcl_pkg::CSR_FLOAT_TRANSITION: float_transition_ff <= csr_wdata;
            bpcl_pkg::CSR_REMOVAL_JUMP:     removal_jump_ff     <= csr_wdata[DROP_W-1:0];
            bpcl_pkg::CSR_REINSERT:         reinsert_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: input register then result register
   // ---------------------------------------------------------------------
   logic            s1_valid_ff, s1_valid_in;
   logic [MV_W-1:0] s1_mv_ff;
   logic            s1_pin_ff, s1_host_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;   // result register can take a new sample
   logic            advance;    // input register moves into result register
   logic            take;       // req transfer

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_mv_ff   <= req_voltage_mv;
         s1_pin_ff  <= req_charge_pin;
         s1_host_ff <= req_usb_host;
      end
   end

   // ---------------------------------------------------------------------
   // Presence and charger latch state
   // ---------------------------------------------------------------------
   logic            absent_latch_ff, absent_latch_in;
   logic            charger_latch_ff, charger_latch_in;
   logic [MV_W-1:0] reference_mv_ff, reference_mv_in;
   logic            seen_sample_ff;
   logic [MV_W-1:0] last_mv_ff;
   logic            last_pin_ff, last_battery_ff, last_usb_ff;

   logic            plausible, just_connected, start_at_float, jumped;
   logic            battery, usb;
   logic [MV_W:0]   jump_level;    // last sample plus removal step
   logic [MV_W:0]   release_level; // this sample plus release drop
   logic [MV_W-1:0] peak_mv;
   logic [PCT_W-1:0] curve_pct;

   assign plausible = (s1_mv_ff >= min_plausible_ff) && (s1_mv_ff <= max_plausible_ff);

   // external power first seen on this sample: skip the removal tests
   assign just_connected = seen_sample_ff && !last_usb_ff && (s1_host_ff || s1_pin_ff);

   // charge starts right at float level: empty holder, charger output only
   assign start_at_float = seen_sample_ff && last_battery_ff && !just_connected
                         && !last_pin_ff && s1_pin_ff
                         && (s1_mv_ff >= float_transition_ff);

   assign jump_level = {1'b0, last_mv_ff} + (MV_W+1)'(removal_jump_ff);
   assign jumped     = seen_sample_ff && last_battery_ff && s1_pin_ff && !just_connected
                     && (s1_mv_ff >= float_ff)
                     && ({1'b0, s1_mv_ff} >= jump_level);

   always_comb begin
      absent_latch_in = absent_latch_ff;
      if (!plausible || start_at_float || jumped) begin
         absent_latch_in = 1'b1;
      end else if (absent_latch_ff) begin
         // cleared by a reading that looks like a real cell again
         if ((s1_mv_ff < reinsert_ff) || (!s1_pin_ff && (s1_mv_ff < float_transition_ff))) begin
            absent_latch_in = 1'b0;
         end
      end
   end

   assign battery = plausible && !absent_latch_in;

   assign peak_mv       = (s1_mv_ff > reference_mv_ff) ? s1_mv_ff : reference_mv_ff;
   assign release_level = {1'b0, s1_mv_ff} + (MV_W+1)'(release_drop_ff);

   // Charger latch: track the peak while the pin is active; once the peak
   // reaches termination, keep reporting power after the pin drops until
   // the voltage sags or leaves the plausible window.
   always_comb begin
      charger_latch_in = charger_latch_ff;
      reference_mv_in  = reference_mv_ff;
      if (s1_pin_ff) begin
         reference_mv_in  = peak_mv;
         charger_latch_in = peak_mv >= termination_ff;
      end else if (charger_latch_ff) begin
         if (!plausible || (s1_mv_ff < termination_ff)
             || (release_level <= {1'b0, reference_mv_ff})) begin
            charger_latch_in = 1'b0;
            reference_mv_in  = '0;
         end
      end else begin
         reference_mv_in = '0;
      end
   end

   assign usb = s1_host_ff || s1_pin_ff || charger_latch_in;

   bpcl_percent u_percent (
      .voltage_mv (s1_mv_ff),
      .percent    (curve_pct)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         absent_latch_ff  <= 1'b0;
         charger_latch_ff <= 1'b0;
         reference_mv_ff  <= '0;
         seen_sample_ff   <= 1'b0;
         last_mv_ff       <= '0;
         last_pin_ff      <= 1'b0;
         last_battery_ff  <= 1'b0;
         last_usb_ff      <= 1'b0;
      end else if (advance) begin
         absent_latch_ff  <= absent_latch_in;
         charger_latch_ff <= charger_latch_in;
         reference_mv_ff  <= reference_mv_in;
         seen_sample_ff   <= 1'b1;
         last_mv_ff       <= s1_mv_ff;
         last_pin_ff      <= s1_pin_ff;
         last_battery_ff  <= battery;
         last_usb_ff      <= usb;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic             rsp_battery_ff, rsp_usb_ff, rsp_charging_ff;
   logic [PCT_W-1:0] rsp_percent_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_battery_ff  <= battery;
         rsp_usb_ff      <= usb;
         rsp_charging_ff <= usb && battery;
         rsp_percent_ff  <= battery ? curve_pct : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_fitted = rsp_battery_ff;
   assign rsp_ext_power   = rsp_usb_ff;
   assign rsp_charging    = rsp_charging_ff;
   assign rsp_percent     = rsp_percent_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_pct_without_battery: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_battery_ff |-> rsp_percent_ff == '0)
      else $error("percent reported with battery absent");

   a_pct_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_percent_ff <= bpcl_pkg::PCT_FULL)
      else $error("percent above full scale");

   a_reference_owner: assert property (@(posedge clock) disable iff (reset)
      reference_mv_ff != '0 |-> (last_pin_ff || charger_latch_ff))
      else $error("peak reference held without pin or charger latch");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* bench/tb_battery_presence_and_charger_latch.sv */
// Self-checking bench for battery_presence_and_charger_latch: directed and random
// battery samples, register settings changed between phases, results checked in order.
// Depends on bpcl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_battery_presence_and_charger_latch;
   import bpcl_pkg::*;

   // One expected result per accepted sample
   typedef struct packed {
      logic             battery;
      logic             usb;
      logic             charging;
      logic [PCT_W-1:0] pct;
   } status_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [MV_W-1:0]      req_voltage_mv;
   logic                 req_charge_pin;
   logic                 req_usb_host;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_cell_fitted;
   logic                 rsp_ext_power;
   logic                 rsp_charging;
   logic [PCT_W-1:0]     rsp_percent;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MV_W-1:0]      csr_wdata;

   battery_presence_and_charger_latch i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_voltage_mv      (req_voltage_mv),
      .req_charge_pin      (req_charge_pin),
      .req_usb_host        (req_usb_host),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_fitted     (rsp_cell_fitted),
      .rsp_ext_power       (rsp_ext_power),
      .rsp_charging        (rsp_charging),
      .rsp_percent         (rsp_percent),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------------
   status_type pending_status [$];   // predicted results, oldest first
   int n_errors   = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_settings = 0;
   bit sender_idles   = 1'b0;     // random gaps before each req transfer
   bit receiver_idles = 1'b0;     // random stall after each rsp transfer
   int stall_left     = 0;

   // Register values staged for the next load_settings call
   logic [MV_W-1:0] next_regs [8];

   // Random-walk state for well-formed battery traces
   int walk_mv   = 3800;
   bit walk_pin  = 1'b0;
   bit walk_host = 1'b0;

   // ---------------------------------------------------------------------
   // Predictor: configuration and latch state kept in step with the block
   // ---------------------------------------------------------------------
   int unsigned lim_min_mv, lim_max_mv, term_mv, drop_mv;
   int unsigned float_lvl_mv, trans_lvl_mv, jump_mv, reinsert_lvl_mv;
   bit          absent_q, charger_q, seen_q, prev_pin, prev_battery, prev_usb;
   int unsigned peak_mv, prev_mv;

   function automatic void restore_defaults();
      lim_min_mv      = 32'(MIN_PLAUSIBLE_RST);
      lim_max_mv      = 32'(MAX_PLAUSIBLE_RST);
      term_mv         = 32'(TERMINATION_RST);
      drop_mv         = 32'(RELEASE_DROP_RST);
      float_lvl_mv    = 32'(FLOAT_RST);
      trans_lvl_mv    = 32'(FLOAT_TRANSITION_RST);
      jump_mv         = 32'(REMOVAL_JUMP_RST);
      reinsert_lvl_mv = 32'(REINSERT_RST);
      absent_q     = 1'b0;
      charger_q    = 1'b0;
      seen_q       = 1'b0;
      prev_pin     = 1'b0;
      prev_battery = 1'b0;
      prev_usb     = 1'b0;
      peak_mv      = 0;
      prev_mv      = 0;
   endfunction

   function automatic void apply_register(csr_index_type idx, logic [MV_W-1:0] d);
      case (idx)
         CSR_MIN_PLAUSIBLE:    lim_min_mv      = 32'(d);
         CSR_MAX_PLAUSIBLE:    lim_max_mv      = 32'(d);
         CSR_TERMINATION:      term_mv         = 32'(d);
         CSR_RELEASE_DROP:     drop_mv         = 32'(d[DROP_W-1:0]);
         CSR_FLOAT:            float_lvl_mv    = 32'(d);
         CSR_FLOAT_TRANSITION: trans_lvl_mv    = 32'(d);
         CSR_REMOVAL_JUMP:     jump_mv         = 32'(d[DROP_W-1:0]);
         CSR_REINSERT:         reinsert_lvl_mv = 32'(d);
         default: ;
      endcase
   endfunction

   // Discharge curve knees: mV and percent
   function automatic int unsigned knee_mv(int k);
      case (k)
         0: return 3300;
         1: return 3520;
         2: return 3640;
         3: return 3760;
         4: return 3880;
         5: return 4000;
         6: return 4120;
         default: return 4200;
      endcase
   endfunction

   function automatic int unsigned knee_pct(int k);
      case (k)
         0: return 0;
         1: return 10;
         2: return 25;
         3: return 45;
         4: return 65;
         5: return 82;
         6: return 96;
         default: return 100;
      endcase
   endfunction

   // Piecewise-linear charge estimate, fraction truncated
   function automatic logic [PCT_W-1:0] charge_percent(int unsigned v);
      int unsigned lo, hi, plo, phi;
      if (v <= knee_mv(0)) return '0;
      for (int k = 1; k < PCT_PTS; k++) begin
         if (v <= knee_mv(k)) begin
            lo  = knee_mv(k - 1);
            hi  = knee_mv(k);
            plo = knee_pct(k - 1);
            phi = knee_pct(k);
            return PCT_W'(plo + ((phi - plo) * (v - lo)) / (hi - lo));
         end
      end
      return PCT_W'(100);
   endfunction

   // Advance the latches by one sample and return what the block must report
   function automatic status_type predict_status(logic [MV_W-1:0] v_in, logic pin, logic host);
      int unsigned v;
      bit plausible, just_connected, start_at_float, jumped, battery, usb;
      status_type s;
      v = 32'(v_in);
      plausible      = (v >= lim_min_mv) && (v <= lim_max_mv);
      just_connected = seen_q && !prev_usb && (host || pin);
      start_at_float = seen_q && prev_battery && !just_connected && !prev_pin && pin &&
                       (v >= trans_lvl_mv);
      jumped         = seen_q && prev_battery && pin && !just_connected &&
                       (v >= float_lvl_mv) && (v >= prev_mv + jump_mv);

      // battery-absent latch: set on implausible level, charge start at float or float jump
      if (!plausible || start_at_float || jumped)
         absent_q = 1'b1;
      else if (absent_q && ((v < reinsert_lvl_mv) || (!pin && (v < trans_lvl_mv))))
         absent_q = 1'b0;
      battery = plausible && !absent_q;

      // charger latch: peak tracks while the pin is active
      if (pin) begin
         if (v > peak_mv) peak_mv = v;
         charger_q = (peak_mv >= term_mv);
      end else if (charger_q) begin
         if (!plausible || (v < term_mv) || (v + drop_mv <= peak_mv)) begin
            charger_q = 1'b0;
            peak_mv   = 0;
         end
      end else begin
         peak_mv = 0;
      end

      usb        = host || pin || charger_q;
      s.battery  = battery;
      s.usb      = usb;
      s.charging = usb && battery;
      s.pct      = battery ? charge_percent(v) : '0;

      seen_q       = 1'b1;
      prev_mv      = v;
      prev_pin     = pin;
      prev_battery = battery;
      prev_usb     = usb;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Result side: stall driven at the falling edge, checked at the rising
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic report_mismatch(string what, logic [MV_W-1:0] got, logic [MV_W-1:0] want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   always @(posedge clock) begin : check_results
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         stall_left = receiver_idles ? $urandom_range(0, 7) : 0;
         if (pending_status.size() == 0) begin
            report_mismatch("result transfer with nothing pending", MV_W'(rsp_percent), '0);
         end else begin
            want = pending_status.pop_front();
            if (rsp_cell_fitted !== want.battery)
               report_mismatch("cell_fitted", MV_W'(rsp_cell_fitted), MV_W'(want.battery));
            if (rsp_ext_power !== want.usb)
               report_mismatch("ext_power", MV_W'(rsp_ext_power), MV_W'(want.usb));
            if (rsp_charging !== want.charging)
               report_mismatch("charging", MV_W'(rsp_charging), MV_W'(want.charging));
            if (rsp_percent !== want.pct)
               report_mismatch("percent", MV_W'(rsp_percent), MV_W'(want.pct));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------

   // One sample transfer. req_valid stays high afterward so back-to-back
   // samples need no gap; a drain lowers it, the next call only when it inserts a gap.
   task automatic send_sample(logic [MV_W-1:0] v, logic pin, logic host);
      int gap;
      gap = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_voltage_mv = v;
      req_charge_pin = pin;
      req_usb_host   = host;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(predict_status(v, pin, host));
      n_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted result is back, then let
   // the two-stage pipe go quiet.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [MV_W-1:0] d);
      csr_index = idx;
      csr_wdata = d;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, d);
      @(negedge clock);
   endtask

   // Writes all eight registers from next_regs while the block is idle
   task automatic load_settings();
      drain_results();
      for (int i = 0; i < 8; i++)
         write_csr(csr_index_type'(i[CSR_IDX_W-1:0]), next_regs[i]);
      csr_valid = 1'b0;
      n_settings++;
   endtask

   task automatic stage_defaults();
      next_regs[CSR_MIN_PLAUSIBLE]    = MIN_PLAUSIBLE_RST;
      next_regs[CSR_MAX_PLAUSIBLE]    = MAX_PLAUSIBLE_RST;
      next_regs[CSR_TERMINATION]      = TERMINATION_RST;
      next_regs[CSR_RELEASE_DROP]     = MV_W'(RELEASE_DROP_RST);
      next_regs[CSR_FLOAT]            = FLOAT_RST;
      next_regs[CSR_FLOAT_TRANSITION] = FLOAT_TRANSITION_RST;
      next_regs[CSR_REMOVAL_JUMP]     = MV_W'(REMOVAL_JUMP_RST);
      next_regs[CSR_REINSERT]         = REINSERT_RST;
   endtask

   // Mostly a plausible battery wandering near the curve with pin and host
   // toggling now and then; the rest is raw noise, partly over the whole field.
   task automatic send_random_sample();
      int r;
      logic [MV_W-1:0] v;
      logic pin, host;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         v    = (r < 4) ? MV_W'($urandom_range(0, 16383)) : MV_W'($urandom_range(0, 9900));
         pin  = 1'($urandom_range(0, 1));
         host = 1'($urandom_range(0, 1));
      end else begin
         if ($urandom_range(0, 19) == 0)
            walk_mv = walk_mv + int'($urandom_range(30, 250));   // removal-like step
         else
            walk_mv = walk_mv + int'($urandom_range(0, 60)) - 30;
         if (walk_mv < 2600) walk_mv = 2600;
         if (walk_mv > 4800) walk_mv = 4800;
         if ($urandom_range(0, 9) == 0)  walk_pin  = ~walk_pin;
         if ($urandom_range(0, 19) == 0) walk_host = ~walk_host;
         v    = MV_W'(walk_mv);
         pin  = walk_pin;
         host = walk_host;
      end
      send_sample(v, pin, host);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         // new idle pattern every 60 samples, some stretches fully busy
         if (i % 60 == 0) begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         send_random_sample();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Plausibility window edges, curve knees and field extremes at reset values
   task automatic test_plausibility_and_curve();
      send_sample(14'd0,     1'b0, 1'b0);
      send_sample(14'd2800,  1'b0, 1'b0);
      send_sample(14'd3300,  1'b0, 1'b0);
      send_sample(14'd3520,  1'b0, 1'b0);
      send_sample(14'd3701,  1'b0, 1'b1);
      send_sample(14'd4200,  1'b0, 1'b1);
      send_sample(14'd4201,  1'b0, 1'b0);
      send_sample(14'd4500,  1'b0, 1'b0);
      send_sample(14'd4501,  1'b0, 1'b0);
      send_sample(14'd16383, 1'b1, 1'b1);
   endtask

   // Latch arms past termination, holds after the pin drops, then releases
   // once below termination; re-armed, it holds through a drop under the release drop
   task automatic test_charger_latch();
      send_sample(14'd3900, 1'b0, 1'b0);
      send_sample(14'd4050, 1'b1, 1'b0);
      send_sample(14'd4130, 1'b1, 1'b0);
      send_sample(14'd4120, 1'b0, 1'b0);
      send_sample(14'd4070, 1'b0, 1'b0);
      send_sample(14'd4130, 1'b1, 1'b0);
      send_sample(14'd4140, 1'b1, 1'b0);
      send_sample(14'd4100, 1'b0, 1'b0);
   endtask

   // With host power steady: charge start already at float, then a jump
   // up to float, each followed by reinsertion
   task automatic test_removal_detect();
      send_sample(14'd3900, 1'b0, 1'b1);
      send_sample(14'd3950, 1'b0, 1'b1);
      send_sample(14'd4190, 1'b1, 1'b1);
      send_sample(14'd4190, 1'b1, 1'b1);
      send_sample(14'd4000, 1'b1, 1'b1);
      send_sample(14'd4100, 1'b1, 1'b1);
      send_sample(14'd4160, 1'b1, 1'b1);
      send_sample(14'd4160, 1'b0, 1'b1);
   endtask

   // Register extremes: all zero, all ones (beyond the stated ranges),
   // an empty plausible window, termination at zero with the release drop at
   // its field maximum, and the range limits
   task automatic test_config_extremes();
      for (int s = 0; s < 5; s++) begin
         stage_defaults();
         case (s)
            0: foreach (next_regs[i]) next_regs[i] = '0;
            1: foreach (next_regs[i]) next_regs[i] = '1;
            2: begin
               next_regs[CSR_MIN_PLAUSIBLE] = 14'd4000;
               next_regs[CSR_MAX_PLAUSIBLE] = 14'd3000;
            end
            3: begin
               next_regs[CSR_TERMINATION]  = 14'd0;
               next_regs[CSR_RELEASE_DROP] = 14'd1023;
            end
            default: begin
               next_regs[CSR_MIN_PLAUSIBLE]    = 14'd0;
               next_regs[CSR_MAX_PLAUSIBLE]    = 14'd9900;
               next_regs[CSR_TERMINATION]      = 14'd9900;
               next_regs[CSR_RELEASE_DROP]     = 14'd1000;
               next_regs[CSR_FLOAT]            = 14'd0;
               next_regs[CSR_FLOAT_TRANSITION] = 14'd0;
               next_regs[CSR_REMOVAL_JUMP]     = 14'd0;
               next_regs[CSR_REINSERT]         = 14'd9900;
            end
         endcase
         load_settings();
         run_random(40);
      end
   endtask

   // Long random traces under defaults and a series of random settings,
   // near-realistic or anywhere in the register fields
   task automatic test_random_walk();
      for (int s = 0; s < 6; s++) begin
         stage_defaults();
         if (s > 0 && $urandom_range(0, 1) == 0) begin
            next_regs[CSR_MIN_PLAUSIBLE]    = MV_W'($urandom_range(2500, 3300));
            next_regs[CSR_MAX_PLAUSIBLE]    = MV_W'($urandom_range(4200, 4700));
            next_regs[CSR_TERMINATION]      = MV_W'($urandom_range(3900, 4250));
            next_regs[CSR_RELEASE_DROP]     = MV_W'($urandom_range(0, 150));
            next_regs[CSR_FLOAT]            = MV_W'($urandom_range(4050, 4250));
            next_regs[CSR_FLOAT_TRANSITION] = MV_W'($urandom_range(4100, 4250));
            next_regs[CSR_REMOVAL_JUMP]     = MV_W'($urandom_range(0, 100));
            next_regs[CSR_REINSERT]         = MV_W'($urandom_range(3950, 4200));
         end else if (s > 0) begin
            foreach (next_regs[i])
               next_regs[i] = ($urandom_range(0, 7) == 0) ? MV_W'($urandom_range(0, 16383))
                                                         : MV_W'($urandom_range(0, 9900));
         end
         load_settings();
         // midway, hold the sender until the result side has caught up
         run_random(80);
         drain_results();
         run_random(80);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_voltage_mv = '0;
      req_charge_pin = 1'b0;
      req_usb_host   = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_MIN_PLAUSIBLE;
      csr_wdata      = '0;
      restore_defaults();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      test_plausibility_and_curve();
      test_charger_latch();
      test_removal_detect();
      test_config_extremes();
      test_random_walk();
      drain_results();

      $display("Covered %0d samples across %0d register settings, %0d results checked.",
               n_sent, n_settings, n_checked);
      $display("Directed latch, removal and curve cases plus random battery traces.");
      if (n_errors == 0) begin
         $display("tb_battery_presence_and_charger_latch: PASS");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("tb_battery_presence_and_charger_latch: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 1200 samples, each
   // with its largest idle gap, its largest stall and the pipe latency)
   initial begin
      #10_000_000;
      $display("timeout");
      $display("tb_battery_presence_and_charger_latch: FAIL");
      $finish;
   end

endmodule
